// File: rtl/dmwbc_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
// Used by dmwbc_regs and direct_mapped_write_back_cache; no dependencies.
package dmwbc_pkg;

  localparam int PADDR_W    = 4;
  localparam int WORD_SHIFT = 2;

  typedef enum logic [1:0] {
    REG_MEM_READ    = 2'd0,
    REG_MEM_WRITE   = 2'd1,
    REG_CACHE_READ  = 2'd2,
    REG_CACHE_WRITE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] mem_read;
    logic [7:0] mem_write;
    logic [7:0] cache_read;
    logic [7:0] cache_write;
  } cost_cfg_t;

  localparam cost_cfg_t COST_RESET = '{
    mem_read:    8'd100,
    mem_write:   8'd50,
    cache_read:  8'd1,
    cache_write: 8'd1
  };

endpackage

// File: rtl/dmwbc_regs.sv
// APB-style register file holding the four cost settings of the cache.
// Depends on dmwbc_pkg.
module dmwbc_regs
  import dmwbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cost_cfg_t          cfg
);

  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= COST_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MEM_READ:    cfg.mem_read    <= pwdata[7:0];
        REG_MEM_WRITE:   cfg.mem_write   <= pwdata[7:0];
        REG_CACHE_READ:  cfg.cache_read  <= pwdata[7:0];
        REG_CACHE_WRITE: cfg.cache_write <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MEM_READ:    prdata = {24'd0, cfg.mem_read};
      REG_MEM_WRITE:   prdata = {24'd0, cfg.mem_write};
      REG_CACHE_READ:  prdata = {24'd0, cfg.cache_read};
      REG_CACHE_WRITE: prdata = {24'd0, cfg.cache_write};
    endcase
  end

endmodule

// File: rtl/direct_mapped_write_back_cache.sv
// Top level: direct-mapped write-back write-allocate cache with its backing memory.
// Depends on dmwbc_pkg and dmwbc_regs.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata {write_data, address}, tuser mode
// m_*       out  m_tvalid/m_tready  tdata {total_cost, read_data}, tuser {wrote_back, hit}
// apb       in   psel/penable       four 8-bit cost registers, pready always high
//
// A hit goes through accept and tag compare. A clean miss adds a line fill, a
// reread and a done state, and a dirty miss also a write-back of the line; the
// backing memory port moves one word a cycle. After reset every backing memory
// word is cleared with s_tready low. A stalled result holds in the output register.
module direct_mapped_write_back_cache
  import dmwbc_pkg::*;
#(
  parameter int OFFSET_BITS_P = 6,
  parameter int INDEX_BITS_P  = 8,
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [47:0]        s_tdata,   // address[15:0], write_data[47:16]
  input  logic [0:0]         s_tuser,   // mode[0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [63:0]        m_tdata,   // read_data[31:0], total_cost[63:32]
  output logic [1:0]         m_tuser,   // hit[0], wrote_back[1]
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int OB    = OFFSET_BITS_P;
  localparam int IB    = INDEX_BITS_P;
  localparam int WW    = OB - WORD_SHIFT;
  localparam int NW    = 1 << WW;
  localparam int LINES = 1 << IB;
  localparam int AW16  = (MEM_ADDR_BITS < 16) ? MEM_ADDR_BITS : 16;
  localparam int EXT   = (MEM_ADDR_BITS > OB + IB) ? MEM_ADDR_BITS : OB + IB + 1;
  localparam int TW    = EXT - OB - IB;
  localparam int BW    = MEM_ADDR_BITS - OB;
  localparam int BKW   = MEM_ADDR_BITS - WORD_SHIFT;
  localparam int DAW   = IB + WW;
  localparam logic [WW:0] CNT_END = (WW + 1)'(NW);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_WBACK, ST_FILL, ST_REREAD, ST_DONE
  } state_t;

  cost_cfg_t cfg;

  dmwbc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t           state;
  logic [BKW-1:0]   clr_ptr;
  logic [WW:0]      cnt;
  logic [WW-1:0]    cnt_d;
  logic [31:0]      cost;
  logic             mode_q;
  logic [EXT-1:0]   addr_q;
  logic [31:0]      wdata_q;
  logic             hit_q;
  logic             wb_q;
  logic [LINES-1:0] line_valid;
  logic [LINES-1:0] line_dirty;

  logic [TW-1:0] tag_mem [LINES];
  logic [TW-1:0] tag_rd;
  logic [31:0]   data_mem [1 << DAW];
  logic [31:0]   d_rdata;
  logic [31:0]   back_mem [1 << BKW];
  logic [31:0]   b_rdata;

  logic [EXT-1:0] s_ext;
  logic [IB-1:0]  s_idx;
  logic [WW-1:0]  s_word;
  logic [IB-1:0]  idx_q;
  logic [WW-1:0]  word_q;
  logic [TW-1:0]  tag_q;
  logic [BW-1:0]  new_block;
  logic [TW+IB-1:0] old_full;
  logic [BW-1:0]  old_block;

  logic        accept, slot_free, lookup_hit, need_wb, finish, cnt_last;
  logic [8:0]  miss_cost;
  logic [31:0] cost_fin;
  logic        res_hit, res_wb;

  logic            d_re, d_we;
  logic [DAW-1:0]  d_raddr, d_waddr;
  logic [31:0]     d_wdata;
  logic            b_re, b_we;
  logic [BKW-1:0]  b_raddr, b_waddr;
  logic [31:0]     b_wdata;

  assign s_ext     = EXT'(s_tdata[AW16-1:0]);
  assign s_idx     = s_ext[OB+IB-1:OB];
  assign s_word    = s_ext[OB-1:WORD_SHIFT];
  assign idx_q     = addr_q[OB+IB-1:OB];
  assign word_q    = addr_q[OB-1:WORD_SHIFT];
  assign tag_q     = addr_q[EXT-1:OB+IB];
  assign new_block = addr_q[MEM_ADDR_BITS-1:OB];
  assign old_full  = {tag_rd, idx_q};
  assign old_block = old_full[BW-1:0];

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign slot_free  = !m_tvalid || m_tready;
  assign lookup_hit = line_valid[idx_q] && (tag_rd == tag_q);
  assign need_wb    = line_valid[idx_q] && line_dirty[idx_q];
  assign cnt_last   = (cnt == CNT_END);
  assign finish     = ((state == ST_LOOKUP && lookup_hit) || state == ST_DONE) && slot_free;
  assign miss_cost  = {1'b0, cfg.mem_read} + (need_wb ? {1'b0, cfg.mem_write} : 9'd0);
  assign cost_fin   = cost + 32'(mode_q ? cfg.cache_write : cfg.cache_read);
  assign res_hit    = (state == ST_LOOKUP) ? 1'b1 : hit_q;
  assign res_wb     = (state == ST_LOOKUP) ? 1'b0 : wb_q;

  // memory port control
  always_comb begin
    d_re    = 1'b0;
    d_raddr = {s_idx, s_word};
    d_we    = 1'b0;
    d_waddr = {idx_q, word_q};
    d_wdata = wdata_q;
    b_re    = 1'b0;
    b_raddr = {new_block, cnt[WW-1:0]};
    b_we    = 1'b0;
    b_waddr = {old_block, cnt_d};
    b_wdata = d_rdata;
    unique case (state)
      ST_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_ptr;
        b_wdata = 32'd0;
      end
      ST_IDLE: d_re = accept;
      ST_LOOKUP, ST_DONE: d_we = finish && mode_q;
      ST_WBACK: begin
        d_re    = !cnt_last;
        d_raddr = {idx_q, cnt[WW-1:0]};
        b_we    = (cnt != '0);
      end
      ST_FILL: begin
        b_re    = !cnt_last;
        d_we    = (cnt != '0);
        d_waddr = {idx_q, cnt_d};
        d_wdata = b_rdata;
      end
      ST_REREAD: begin
        d_re    = 1'b1;
        d_raddr = {idx_q, word_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) tag_rd <= tag_mem[s_idx];
    if (state == ST_FILL && cnt_last) tag_mem[idx_q] <= tag_q;
  end

  always_ff @(posedge clk) begin
    if (d_re) d_rdata <= data_mem[d_raddr];
    if (d_we) data_mem[d_waddr] <= d_wdata;
  end

  always_ff @(posedge clk) begin
    if (b_re) b_rdata <= back_mem[b_raddr];
    if (b_we) back_mem[b_waddr] <= b_wdata;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_ptr    <= '0;
      cnt        <= '0;
      cost       <= '0;
      m_tvalid   <= 1'b0;
      line_valid <= '0;
      line_dirty <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (&clr_ptr) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            mode_q  <= s_tuser[0];
            addr_q  <= s_ext;
            wdata_q <= s_tdata[47:16];
            state   <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          hit_q <= lookup_hit;
          wb_q  <= !lookup_hit && need_wb;
          if (lookup_hit) begin
            state <= slot_free ? ST_IDLE : ST_DONE;
          end else begin
            cost  <= cost + 32'(miss_cost);
            cnt   <= '0;
            state <= need_wb ? ST_WBACK : ST_FILL;
          end
        end
        ST_WBACK: begin
          cnt   <= cnt_last ? '0 : cnt + 1'b1;
          cnt_d <= cnt[WW-1:0];
          if (cnt_last) state <= ST_FILL;
        end
        ST_FILL: begin
          cnt   <= cnt + 1'b1;
          cnt_d <= cnt[WW-1:0];
          if (cnt_last) begin
            line_valid[idx_q] <= 1'b1;
            line_dirty[idx_q] <= 1'b0;
            state             <= ST_REREAD;
          end
        end
        ST_REREAD: state <= ST_DONE;
        ST_DONE: begin
          if (slot_free) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
      if (finish) begin
        m_tvalid       <= 1'b1;
        m_tdata[31:0]  <= mode_q ? 32'd0 : d_rdata;
        m_tdata[63:32] <= cost_fin;
        m_tuser        <= {res_wb, res_hit};
        cost           <= cost_fin;
        if (mode_q) line_dirty[idx_q] <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_LOOKUP))
    else $error("accepted request did not enter tag lookup");

  a_wback_needs_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WBACK) |-> (line_valid[idx_q] && line_dirty[idx_q]))
    else $error("write-back of a line that is not valid and dirty");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && cnt_last) |=> (line_valid[idx_q] && state == ST_REREAD))
    else $error("line fill did not validate the line");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result reports both hit and write-back");

endmodule

// File: bench/tb.sv
// Self-checking bench for direct_mapped_write_back_cache: streams cache requests,
// predicts each response with a behavioral cache and memory, and checks every field.
// Depends on dmwbc_pkg and the cache RTL.
module tb;
  import dmwbc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam bit ACC_LOAD    = 1'b0;
  localparam bit ACC_STORE   = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] addr;
    logic [31:0] wdata;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic        wrote_back;
    logic [31:0] total_cost;
  } outcome_t;

  logic               clk;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [47:0]        s_tdata  = '0;
  logic [0:0]         s_tuser  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [63:0]        m_tdata;
  logic [1:0]         m_tuser;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  direct_mapped_write_back_cache u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // behavioral cache state
  bit          line_ok    [256];
  bit          line_dirty [256];
  bit [1:0]    line_tag   [256];
  bit [31:0]   line_data  [4096];
  bit [31:0]   mem_data   [16384];
  bit [31:0]   cost_total = '0;
  cost_cfg_t   costs      = COST_RESET;

  access_t     pending[$];
  outcome_t    awaited[$];
  bit [7:0]    hot_lines[4];
  int          errors       = 0;
  int          cycles       = 0;
  int          results_seen = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("direct_mapped_write_back_cache: mismatch");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    if (errors <= 20) $display("cycle %0d: %s", cycles, what);
  endtask

  task automatic cache_access(input access_t a, output outcome_t o);
    bit [3:0] w;
    bit [7:0] ix;
    bit [1:0] tg;
    int       base;
    o    = '0;
    w    = a.addr[5:2];
    ix   = a.addr[13:6];
    tg   = a.addr[15:14];
    base = ix * 16;
    if (line_ok[ix] && line_tag[ix] == tg) begin
      o.hit = 1'b1;
    end else begin
      cost_total += costs.mem_read;
      if (line_ok[ix] && line_dirty[ix]) begin
        for (int i = 0; i < 16; i++) mem_data[{line_tag[ix], ix, 4'(i)}] = line_data[base + i];
        cost_total += costs.mem_write;
        o.wrote_back = 1'b1;
      end
      for (int i = 0; i < 16; i++) line_data[base + i] = mem_data[{tg, ix, 4'(i)}];
      line_ok[ix]    = 1'b1;
      line_tag[ix]   = tg;
      line_dirty[ix] = 1'b0;
    end
    if (a.mode == ACC_LOAD) begin
      o.read_data = line_data[base + w];
      cost_total += costs.cache_read;
    end else begin
      line_data[base + w] = a.wdata;
      cost_total += costs.cache_write;
      line_dirty[ix] = 1'b1;
    end
    o.total_cost = cost_total;
  endtask

  // request driver
  bit tx_calm = 1'b0;
  int tx_gap  = 0;
  always @(posedge clk) begin
    access_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (tx_gap != 0) begin
        tx_gap   <= tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        item = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {item.wdata, item.addr};
        s_tuser  <= item.mode;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap <= tx_calm ? 0 : $urandom_range(0, 11);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // response side: per-response stalls plus one long hold-off
  bit rx_calm   = 1'b0;
  bit hold_done = 1'b0;
  int rx_wait   = 0;
  int rx_hold   = 0;
  always @(posedge clk) begin
    int w;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen == 150) begin
      hold_done <= 1'b1;
      rx_hold   <= 400;
      m_tready  <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= (rx_hold == 1);
    end else if (m_tvalid && m_tready) begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      w = rx_calm ? 0 : $urandom_range(0, 11);
      rx_wait  <= w;
      m_tready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // prediction on accepted requests, comparison on accepted responses
  always @(posedge clk) begin
    access_t  a;
    outcome_t want;
    outcome_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        a.mode  = s_tuser[0];
        a.addr  = s_tdata[15:0];
        a.wdata = s_tdata[47:16];
        cache_access(a, want);
        awaited.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        got.read_data  = m_tdata[31:0];
        got.total_cost = m_tdata[63:32];
        got.hit        = m_tuser[0];
        got.wrote_back = m_tuser[1];
        if (awaited.size() == 0) begin
          report("response with no request outstanding");
        end else begin
          want = awaited.pop_front();
          if (got.read_data != want.read_data)
            report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
          if (got.hit != want.hit)
            report($sformatf("hit %0d, expected %0d", got.hit, want.hit));
          if (got.wrote_back != want.wrote_back)
            report($sformatf("wrote_back %0d, expected %0d", got.wrote_back, want.wrote_back));
          if (got.total_cost != want.total_cost)
            report($sformatf("total_cost %0d, expected %0d", got.total_cost, want.total_cost));
        end
      end
    end
  end

  task automatic cfg_write(input reg_idx_t r, input bit [7:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {24'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_MEM_READ:    costs.mem_read    = v;
      REG_MEM_WRITE:   costs.mem_write   = v;
      REG_CACHE_READ:  costs.cache_read  = v;
      REG_CACHE_WRITE: costs.cache_write = v;
    endcase
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] != v)
      report($sformatf("register %0d reads %h, expected %h", r, prdata[7:0], v));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_costs(input bit [7:0] mr, input bit [7:0] mw,
                           input bit [7:0] cr, input bit [7:0] cw);
    cfg_write(REG_MEM_READ, mr);
    cfg_write(REG_MEM_WRITE, mw);
    cfg_write(REG_CACHE_READ, cr);
    cfg_write(REG_CACHE_WRITE, cw);
  endtask

  task automatic drain();
    while (pending.size() != 0 || s_tvalid || awaited.size() != 0) @(posedge clk);
  endtask

  function automatic access_t random_access();
    access_t a;
    a.mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       a.wdata = '0;
      1:       a.wdata = '1;
      default: a.wdata = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0)
      a.addr = 16'($urandom);
    else
      a.addr = {2'($urandom_range(0, 3)), hot_lines[$urandom_range(0, 3)],
                6'($urandom_range(0, 63))};
    return a;
  endfunction

  task automatic random_phase(input int count);
    foreach (hot_lines[i]) hot_lines[i] = 8'($urandom_range(0, 255));
    hot_lines[0] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
    repeat (count) pending.push_back(random_access());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // clean miss, hit, unaligned, conflict evictions, extremes of address and data
    pending.push_back('{ACC_LOAD,  16'h0000, 32'h0000_0000});
    pending.push_back('{ACC_STORE, 16'h0004, 32'hFFFF_FFFF});
    pending.push_back('{ACC_LOAD,  16'h0007, 32'hFFFF_FFFF});
    pending.push_back('{ACC_LOAD,  16'h4000, 32'h0000_0000});
    pending.push_back('{ACC_LOAD,  16'h0004, 32'h0000_0000});
    pending.push_back('{ACC_STORE, 16'hFFFF, 32'h0000_0000});
    pending.push_back('{ACC_STORE, 16'hFFFC, 32'hA5A5_5A5A});
    pending.push_back('{ACC_LOAD,  16'hFFFE, 32'h0000_0000});
    pending.push_back('{ACC_STORE, 16'h3FC0, 32'h1234_5678});
    pending.push_back('{ACC_LOAD,  16'hFFFC, 32'hFFFF_FFFF});
    pending.push_back('{ACC_LOAD,  16'h3FC1, 32'h0000_0000});
    pending.push_back('{ACC_STORE, 16'h8040, 32'h8000_0001});
    pending.push_back('{ACC_STORE, 16'hC07F, 32'h7FFF_FFFE});
    pending.push_back('{ACC_LOAD,  16'h8040, 32'h0000_0000});
    pending.push_back('{ACC_LOAD,  16'hC07C, 32'h0000_0000});
    drain();

    set_costs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_phase(230);
    set_costs(8'h00, 8'h00, 8'h00, 8'h00);
    random_phase(230);
    set_costs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(230);
    set_costs(8'h00, 8'hFF, 8'hFF, 8'h00);
    random_phase(235);

    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("direct_mapped_write_back_cache: match");
    else
      $display("direct_mapped_write_back_cache: mismatch");
    $finish;
  end

endmodule
